>>> rtl/per_source_sequence_freshness_check_defines.svh
// Assertion macros for the checker module of the freshness filter.
// Depends on nothing; each macro expects signals named clock and reset in scope.
`ifndef PER_SOURCE_SEQUENCE_FRESHNESS_CHECK_DEFINES_SVH
`define PER_SOURCE_SEQUENCE_FRESHNESS_CHECK_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PSFC_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold the given constant number of cycles after the antecedent.
`define PSFC_ASSERT_LATER(label, ante, dly, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##dly (cons)) \
      else $error(msg);

`endif

>>> rtl/psfc_pkg.sv
// Package for the per-source sequence freshness filter: payload types and sizes.
// Used by the top level and by its port checker.
package psfc_pkg;

   localparam int ADDR_BITS          = 32;
   localparam int SEQ_FIELD_BITS     = 16;
   localparam int TABLE_DEPTH_DEFAULT = 16;
   localparam int SEQ_BITS_DEFAULT    = 16;

   typedef struct packed {
      logic [ADDR_BITS-1:0]      source_address;
      logic [SEQ_FIELD_BITS-1:0] sequence_number;
   } req_type;

   typedef struct packed {
      logic forward;
      logic new_source;
      logic table_full;
   } rsp_type;

endpackage

>>> rtl/per_source_sequence_freshness_check.sv
// A request passes the input register and the table lookup; its result is registered and shown for one cycle.
// Throughput: one request per cycle while busy is low; the single-pass table lookup sets that figure.
// busy is high only while reset is asserted; results cannot be stalled by the receiver.
// Reset clears the pipeline strobes and every table valid bit.
// Depends on psfc_pkg.
module per_source_sequence_freshness_check #(
   parameter int TABLE_DEPTH = psfc_pkg::TABLE_DEPTH_DEFAULT,
   parameter int SEQ_BITS    = psfc_pkg::SEQ_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  psfc_pkg::req_type req_data,
   output logic              rsp_valid,
   output psfc_pkg::rsp_type rsp_data
);
   import psfc_pkg::*;

   localparam logic [SEQ_BITS-1:0] HALF_RANGE = {1'b0, {(SEQ_BITS-1){1'b1}}};

   logic                      valid_ff;
   req_type                   req_ff;
   logic                      rsp_valid_ff;
   rsp_type                   rsp_ff;
   rsp_type                   rsp_in;

   logic [TABLE_DEPTH-1:0]    entry_valid_ff;
   logic [ADDR_BITS-1:0]      entry_address_ff  [TABLE_DEPTH];
   logic [SEQ_BITS-1:0]       entry_sequence_ff [TABLE_DEPTH];

   logic [TABLE_DEPTH-1:0]    hit_vec;
   logic [TABLE_DEPTH-1:0]    free_vec;
   logic [TABLE_DEPTH-1:0]    free_onehot;
   logic [TABLE_DEPTH-1:0]    seq_we;
   logic [TABLE_DEPTH-1:0]    alloc_we;
   logic                      hit;
   logic                      full;
   logic [SEQ_BITS-1:0]       prev_seq;
   logic [SEQ_BITS-1:0]       cur_seq;
   logic [31:0]               seq_wide;
   logic                      prev_zero;
   logic                      newer;
   logic                      update;

   assign busy = reset;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= start && !busy;
      end
      req_ff <= req_data;
   end

   assign seq_wide = {{(32-SEQ_FIELD_BITS){1'b0}}, req_ff.sequence_number};
   assign cur_seq  = seq_wide[SEQ_BITS-1:0];

   // Parallel match over the table; addresses are unique, so at most one entry hits.
   always_comb begin
      prev_seq = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         hit_vec[i] = entry_valid_ff[i] && (entry_address_ff[i] == req_ff.source_address);
         if (hit_vec[i]) begin
            prev_seq = prev_seq | entry_sequence_ff[i];
         end
      end
   end

   assign hit         = |hit_vec;
   assign free_vec    = ~entry_valid_ff;
   assign free_onehot = free_vec & (~free_vec + TABLE_DEPTH'(1));
   assign full        = ~|free_vec;

   // Serial number comparison with wraparound at half the sequence range.
   assign newer = ((cur_seq > prev_seq) && ((cur_seq - prev_seq) <= HALF_RANGE)) ||
                  ((prev_seq > cur_seq) && ((prev_seq - cur_seq) > HALF_RANGE));
   assign prev_zero = (prev_seq == '0);
   assign update    = prev_zero || newer;

   always_comb begin
      if (hit) begin
         rsp_in.forward    = update;
         rsp_in.new_source = prev_zero;
         rsp_in.table_full = 1'b0;
      end else begin
         rsp_in.forward    = 1'b1;
         rsp_in.new_source = 1'b1;
         rsp_in.table_full = full;
      end
   end

   always_comb begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         alloc_we[i] = valid_ff && !hit && free_onehot[i];
         seq_we[i]   = alloc_we[i] || (valid_ff && hit_vec[i] && update);
      end
   end

   // Table storage; only the valid bits are reset.
   always_ff @(posedge clock) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (reset) begin
            entry_valid_ff[i] <= 1'b0;
         end else if (alloc_we[i]) begin
            entry_valid_ff[i] <= 1'b1;
         end
         if (alloc_we[i]) begin
            entry_address_ff[i] <= req_ff.source_address;
         end
         if (seq_we[i]) begin
            entry_sequence_ff[i] <= cur_seq;
         end
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= valid_ff;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> rtl/psfc_checker.sv
// Port-level checker for the freshness filter, bound to the top level below.
// Depends on psfc_pkg and per_source_sequence_freshness_check_defines.svh.
`include "per_source_sequence_freshness_check_defines.svh"

module psfc_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input psfc_pkg::rsp_type rsp_data
);
   import psfc_pkg::*;

   logic accept;

   assign accept = start && !busy;

   // Every accepted request yields its result through the input and result registers.
   `PSFC_ASSERT_LATER(a_rsp_follows_req, accept, 2, rsp_valid, "request produced no result")

   `PSFC_ASSERT_SAME(a_no_spurious_rsp, rsp_valid, $past(accept, 2), "result without a request")

   // A source that could not be stored is still forwarded as new.
   `PSFC_ASSERT_SAME(a_full_implies_new, rsp_valid && rsp_data.table_full,
      rsp_data.forward && rsp_data.new_source, "table full result not forwarded as new")

   // A discard only happens for a known source with a nonzero stored number.
   `PSFC_ASSERT_SAME(a_discard_known, rsp_valid && !rsp_data.forward,
      !rsp_data.new_source && !rsp_data.table_full, "discard flagged as new source")

endmodule

bind per_source_sequence_freshness_check psfc_checker u_psfc_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
